/* hdl/hkd_pkg.sv */
// Shared constants and types for the hall key threshold debounce core.
// Used by hall_key_threshold_debounce_core; no dependencies.
package hkd_pkg;

  localparam int NUM_KEYS = 48;
  localparam int KEY_W    = 6;
  localparam int ADC_W    = 12;
  localparam int DEB_W    = 8;
  localparam int TIME_W   = 32;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic [ADC_W-1:0] THRESH_RESET   = ADC_W'(413);
  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = DEB_W'(5);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME   = 1'b1;

  // request codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // one entry of the per-key state memory
  typedef struct packed {
    logic              pressed;
    logic [TIME_W-1:0] last_ms;
  } key_entry_t;

  localparam int ENTRY_W = $bits(key_entry_t);

endpackage

/* hdl/hkd_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// Read-first on address collision. No dependencies.
module hkd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/hall_key_threshold_debounce_core.sv */
// Hall key threshold debounce core: top level.
// Depends on hkd_pkg and hkd_ram.
//
// Takes one item per cycle. A tick item advances the millisecond counter and gives no
// result; a sample item for a key below the key count gives one result after a memory
// read, then an update into the output register; other samples are dropped. Per-key
// state (debounced level and last change time) sits in one RAM with a registered read; the
// write of the previous sample is forwarded, so samples of the same key may follow back to
// back. An entry never written reads as released with change time zero, tracked by one
// valid bit per key cleared at reset, so no clearing pass is needed. Throughput drops only
// when the output register is full and not taken.
module hall_key_threshold_debounce_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_req_type,
  input  logic [hkd_pkg::KEY_W-1:0]      in_key_index,
  input  logic [hkd_pkg::ADC_W-1:0]      in_adc_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [hkd_pkg::KEY_W-1:0]      out_key_number,
  output logic                           out_pressed,
  output logic                           out_changed,
  input  logic                           cfg_we,
  input  logic [hkd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hkd_pkg::CFG_W-1:0]      cfg_data
);

  localparam int AW = $clog2(hkd_pkg::NUM_KEYS);

  logic [hkd_pkg::ADC_W-1:0]  thresh_r;
  logic [hkd_pkg::DEB_W-1:0]  deb_r;
  logic [hkd_pkg::TIME_W-1:0] now_r;

  logic                       s1_valid_r;
  logic [hkd_pkg::KEY_W-1:0]  s1_key_r;
  logic                       s1_raw_r;
  logic [hkd_pkg::TIME_W-1:0] s1_now_r;

  logic                       fwd_valid_r;
  logic [AW-1:0]              fwd_addr_r;
  hkd_pkg::key_entry_t        fwd_data_r;

  logic [hkd_pkg::NUM_KEYS-1:0] ent_valid_r;

  logic                       out_valid_r;
  logic [hkd_pkg::KEY_W-1:0]  out_key_r;
  logic                       out_pressed_r;
  logic                       out_changed_r;

  logic                       in_acc;
  logic                       s1_adv;
  logic                       take_sample;
  logic                       ram_re;
  logic [hkd_pkg::ENTRY_W-1:0] ram_rdata;
  hkd_pkg::key_entry_t        cur;
  hkd_pkg::key_entry_t        wr_data;
  logic [hkd_pkg::TIME_W-1:0] elapsed;
  logic                       flip;
  logic                       wr_en;
  logic [AW-1:0]              s1_addr;

  assign s1_adv      = !out_valid_r || out_ready;
  assign in_ready    = !s1_valid_r || s1_adv;
  assign in_acc      = in_valid && in_ready;
  assign take_sample = in_acc && (in_req_type == hkd_pkg::REQ_SAMPLE) &&
                       (32'(in_key_index) < hkd_pkg::NUM_KEYS);
  assign ram_re      = take_sample;
  assign s1_addr     = s1_key_r[AW-1:0];

  hkd_ram #(
    .WIDTH(hkd_pkg::ENTRY_W),
    .DEPTH(hkd_pkg::NUM_KEYS)
  ) u_state_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(s1_addr),
    .wdata(wr_data),
    .re   (ram_re),
    .raddr(in_key_index[AW-1:0]),
    .rdata(ram_rdata)
  );

  // current entry: forwarded write first, then memory, else reset value
  always_comb begin
    if (fwd_valid_r && (fwd_addr_r == s1_addr)) begin
      cur = fwd_data_r;
    end else if (ent_valid_r[s1_addr]) begin
      cur = hkd_pkg::key_entry_t'(ram_rdata);
    end else begin
      cur = '0;
    end
    elapsed         = s1_now_r - cur.last_ms;
    flip            = (elapsed > {{(hkd_pkg::TIME_W-hkd_pkg::DEB_W){1'b0}}, deb_r}) &&
                      (s1_raw_r != cur.pressed);
    wr_en           = s1_valid_r && s1_adv && flip;
    wr_data.pressed = s1_raw_r;
    wr_data.last_ms = s1_now_r;
  end

  // configuration and time base
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= hkd_pkg::THRESH_RESET;
      deb_r    <= hkd_pkg::DEBOUNCE_RESET;
      now_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          hkd_pkg::CFG_PRESS_THRESHOLD: thresh_r <= cfg_data[hkd_pkg::ADC_W-1:0];
          hkd_pkg::CFG_DEBOUNCE_TIME:   deb_r    <= cfg_data[hkd_pkg::DEB_W-1:0];
          default: ;
        endcase
      end
      if (in_acc && (in_req_type == hkd_pkg::REQ_TICK)) begin
        now_r <= now_r + 1'b1;
      end
    end
  end

  // stage 1 control, forwarding, valid bits and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      ent_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= take_sample;
      end
      if (wr_en) begin
        fwd_valid_r          <= 1'b1;
        ent_valid_r[s1_addr] <= 1'b1;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take_sample) begin
      s1_key_r <= in_key_index;
      s1_raw_r <= (in_adc_value < thresh_r);
      s1_now_r <= now_r;
    end
    if (wr_en) begin
      fwd_addr_r <= s1_addr;
      fwd_data_r <= wr_data;
    end
    if (s1_adv && s1_valid_r) begin
      out_key_r     <= s1_key_r;
      out_pressed_r <= flip ? s1_raw_r : cur.pressed;
      out_changed_r <= flip;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key_number = out_key_r;
  assign out_pressed    = out_pressed_r;
  assign out_changed    = out_changed_r;

endmodule
